FILE: design/rc4_pkg.sv
// Package for the RC4 keystream cipher.
// Holds byte and state types, operation codes and the permutation memory request.
// No dependencies.
package rc4_pkg;

  localparam int PERM_DEPTH = 256;

  typedef logic [7:0] byte_t;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_D_RD_J,
    ST_D_RD_T,
    ST_D_OUT,
    ST_K_RD,
    ST_K_ACC,
    ST_K_WR_N,
    ST_K_WR_A
  } state_t;

  typedef struct packed {
    logic  rd_en;
    byte_t rd_addr;
    logic  wr_en;
    byte_t wr_addr;
    byte_t wr_data;
    logic  clr;
  } perm_req_t;

endpackage

FILE: design/rc4_in_if.sv
// Input channel of the RC4 keystream cipher: one key or data word per handshake.
// Depends on rc4_pkg.
interface rc4_in_if import rc4_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  operation;
  byte_t byte_value;
  logic  key_last;

  modport source (output valid, output operation, output byte_value, output key_last,
                  input ready);
  modport sink (input valid, input operation, input byte_value, input key_last,
                output ready);
endinterface

FILE: design/rc4_out_if.sv
// Result channel of the RC4 keystream cipher: one cipher word per handshake.
// Depends on rc4_pkg.
interface rc4_out_if import rc4_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink (input valid, input cipher_byte, output ready);
endinterface

FILE: design/rc4_keystream_cipher.sv
// RC4 keystream cipher. A data word passes through D_RD_J, D_RD_T and D_OUT before the next
// word is taken; its cipher word is loaded in D_OUT once the output register is free and waits
// there. A key word is taken in IDLE; the last key word starts the key schedule, 256 steps of
// K_RD, K_ACC, K_WR_N and K_WR_A on the permutation memory, and no word is taken until it
// ends. Reset is synchronous: the permutation reads as identity at
// once through cleared valid bits, indices and key length are zero, no clearing pass.
module rc4_keystream_cipher import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  rc4_in_if.sink    in_word,
  rc4_out_if.source out_word
);

  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  perm_req_t      perm_req;
  byte_t          perm_rd;
  logic           key_wr_en;
  logic [KAW-1:0] key_wr_addr;
  byte_t          key_wr_data;
  logic           key_rd_en;
  logic [KAW-1:0] key_rd_addr;
  byte_t          key_rd;

  rc4_engine #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .out_word    (out_word),
    .perm_req    (perm_req),
    .perm_rd     (perm_rd),
    .key_wr_en   (key_wr_en),
    .key_wr_addr (key_wr_addr),
    .key_wr_data (key_wr_data),
    .key_rd_en   (key_rd_en),
    .key_rd_addr (key_rd_addr),
    .key_rd      (key_rd)
  );

  rc4_perm_ram u_perm_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (perm_rd)
  );

  rc4_key_ram #(
    .DEPTH (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd)
  );

endmodule

FILE: design/rc4_perm_ram.sv
// Permutation memory: 256 bytes, one write and one registered read per cycle.
// Per-entry valid bits make an unwritten entry read as its own index.
// Depends on rc4_pkg.
module rc4_perm_ram import rc4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  perm_req_t req,
  output byte_t     rd_data
);

  byte_t                   mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0]   valid_r;
  byte_t                   rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/rc4_key_ram.sv
// Key store: one byte per key position, one write and one registered read per cycle.
// Contents are undefined until written. Depends on rc4_pkg.
module rc4_key_ram import rc4_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  byte_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output byte_t         rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/rc4_engine.sv
// Sequencer of the RC4 keystream cipher with its one shared byte adder.
// Drives the permutation and key memories and holds the output register.
// Depends on rc4_pkg, rc4_in_if and rc4_out_if.
module rc4_engine import rc4_pkg::*; #(
  parameter int MAX_KEY_BYTES = 256,
  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
  localparam int KLW = $clog2(MAX_KEY_BYTES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  rc4_in_if.sink         in_word,
  rc4_out_if.source      out_word,
  output perm_req_t      perm_req,
  input  byte_t          perm_rd,
  output logic           key_wr_en,
  output logic [KAW-1:0] key_wr_addr,
  output byte_t          key_wr_data,
  output logic           key_rd_en,
  output logic [KAW-1:0] key_rd_addr,
  input  byte_t          key_rd
);

  state_t         state_r, state_nxt;
  byte_t          idx_i_r, idx_i_nxt;
  byte_t          idx_j_r, idx_j_nxt;
  logic [KLW-1:0] klen_r, klen_nxt;
  logic [KAW-1:0] kidx_r, kidx_nxt;
  byte_t          hold_a_r, hold_a_nxt;
  byte_t          hold_b_r, hold_b_nxt;
  byte_t          t_r, t_nxt;
  byte_t          val_r, val_nxt;
  logic           out_valid_r, out_valid_nxt;
  byte_t          out_byte_r, out_byte_nxt;

  byte_t          add_a, add_b, add_c, sum;
  byte_t          kb, ks;
  logic           out_free;

  assign kb       = (klen_r == '0) ? 8'd0 : key_rd;
  assign out_free = !out_valid_r || out_word.ready;
  assign ks       = (t_r == idx_j_r) ? hold_a_r :
                    (t_r == idx_i_r) ? hold_b_r : perm_rd;

  always_comb begin
    add_a = idx_i_r;
    add_b = 8'd1;
    add_c = 8'd0;
    unique case (state_r) inside
      ST_D_RD_J: begin
        add_a = idx_j_r;
        add_b = perm_rd;
      end
      ST_K_ACC: begin
        add_a = idx_j_r;
        add_b = perm_rd;
        add_c = kb;
      end
      ST_D_RD_T: begin
        add_a = hold_a_r;
        add_b = perm_rd;
      end
      ST_IDLE, ST_K_WR_A, ST_D_OUT, ST_K_RD, ST_K_WR_N: begin
        add_a = idx_i_r;
        add_b = 8'd1;
      end
      default: begin
        add_a = idx_i_r;
      end
    endcase
  end

  assign sum = add_a + add_b + add_c;

  always_comb begin
    state_nxt     = state_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    klen_nxt      = klen_r;
    kidx_nxt      = kidx_r;
    hold_a_nxt    = hold_a_r;
    hold_b_nxt    = hold_b_r;
    t_nxt         = t_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_byte_nxt  = out_byte_r;
    perm_req      = '0;
    key_wr_en     = 1'b0;
    key_wr_addr   = klen_r[KAW-1:0];
    key_wr_data   = in_word.byte_value;
    key_rd_en     = 1'b0;
    key_rd_addr   = kidx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_word.valid) begin
          if (in_word.operation == OP_DATA) begin
            perm_req.rd_en   = 1'b1;
            perm_req.rd_addr = sum;
            idx_i_nxt        = sum;
            val_nxt          = in_word.byte_value;
            state_nxt        = ST_D_RD_J;
          end else begin
            if (klen_r < KLW'(MAX_KEY_BYTES)) begin
              key_wr_en = 1'b1;
              klen_nxt  = klen_r + KLW'(1);
            end
            if (in_word.key_last) begin
              perm_req.clr = 1'b1;
              idx_i_nxt    = 8'd0;
              idx_j_nxt    = 8'd0;
              kidx_nxt     = '0;
              state_nxt    = ST_K_RD;
            end
          end
        end
      end
      ST_D_RD_J: begin
        idx_j_nxt        = sum;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = sum;
        hold_a_nxt       = perm_rd;
        state_nxt        = ST_D_RD_T;
      end
      ST_D_RD_T: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_i_r;
        perm_req.wr_data = perm_rd;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = sum;
        hold_b_nxt       = perm_rd;
        t_nxt            = sum;
        state_nxt        = ST_D_OUT;
      end
      ST_D_OUT: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_j_r;
        perm_req.wr_data = hold_a_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = val_r ^ ks;
          state_nxt     = ST_IDLE;
        end
      end
      ST_K_RD: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = idx_i_r;
        key_rd_en        = 1'b1;
        state_nxt        = ST_K_ACC;
      end
      ST_K_ACC: begin
        idx_j_nxt        = sum;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = sum;
        hold_a_nxt       = perm_rd;
        state_nxt        = ST_K_WR_N;
      end
      ST_K_WR_N: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_i_r;
        perm_req.wr_data = perm_rd;
        state_nxt        = ST_K_WR_A;
      end
      ST_K_WR_A: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = idx_j_r;
        perm_req.wr_data = hold_a_r;
        idx_i_nxt        = sum;
        if ((KLW'(kidx_r) + KLW'(1)) == klen_r) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + KAW'(1);
        end
        if (idx_i_r == 8'hFF) begin
          idx_j_nxt = 8'd0;
          klen_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_K_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_i_r     <= 8'd0;
      idx_j_r     <= 8'd0;
      klen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      klen_r      <= klen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kidx_r     <= kidx_nxt;
    hold_a_r   <= hold_a_nxt;
    hold_b_r   <= hold_b_nxt;
    t_r        <= t_nxt;
    val_r      <= val_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign in_word.ready        = (state_r == ST_IDLE);
  assign out_word.valid       = out_valid_r;
  assign out_word.cipher_byte = out_byte_r;

endmodule

FILE: sim/rc4_keystream_cipher_tb.sv
`timescale 1ns / 1ps
// Testbench for rc4_keystream_cipher: keys and data words go in with random gaps, and the
// cipher words that come out are checked against a predictor of the RC4 state kept here.
// Depends on rc4_pkg, rc4_in_if, rc4_out_if and the block itself.
module rc4_keystream_cipher_tb;
  import rc4_pkg::*;

  localparam int unsigned KEY_CAPACITY = 256;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef struct {
    logic        op;
    byte_t       val;
    logic        last;
    bit          drain_first;
    int unsigned phase;
  } cipher_word_t;

  logic clk;
  logic rst_n;

  rc4_in_if  in_word ();
  rc4_out_if out_word ();

  rc4_keystream_cipher uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  cipher_word_t word_backlog [$];
  byte_t        cipher_expected [$];

  byte_t       perm_state [256];
  byte_t       key_mem [256];
  int unsigned key_count;
  byte_t       stream_i;
  byte_t       stream_j;

  int unsigned tx_idle_pct [3] = '{35, 81, 0};
  int unsigned rx_idle_pct [3] = '{81, 35, 0};

  int unsigned build_phase;
  int unsigned words_built;
  bit          drain_next;
  int unsigned traffic_phase;
  logic        in_taken;
  int unsigned hold_left;
  bit          long_hold_done;
  int unsigned stall_cycles;

  int unsigned key_words;
  int unsigned data_words;
  int unsigned schedules_run;
  int unsigned results_checked;
  int unsigned error_count;

  function automatic void rc4_advance(input logic op, input byte_t val, input logic last,
                                      output bit emits, output byte_t cipher);
    byte_t acc;
    byte_t hold;
    byte_t t;
    int n;
    emits = 1'b0;
    cipher = '0;
    if (op == OP_KEY) begin
      key_words++;
      if (key_count < KEY_CAPACITY) begin
        key_mem[key_count] = val;
        key_count++;
      end
      if (last) begin
        schedules_run++;
        for (n = 0; n < 256; n++) perm_state[n] = n[7:0];
        acc = '0;
        for (n = 0; n < 256; n++) begin
          acc = acc + perm_state[n] + key_mem[n % key_count];
          hold = perm_state[n];
          perm_state[n] = perm_state[acc];
          perm_state[acc] = hold;
        end
        stream_i = '0;
        stream_j = '0;
        key_count = 0;
      end
    end else begin
      data_words++;
      stream_i = stream_i + 8'd1;
      stream_j = stream_j + perm_state[stream_i];
      hold = perm_state[stream_i];
      perm_state[stream_i] = perm_state[stream_j];
      perm_state[stream_j] = hold;
      t = perm_state[stream_i] + perm_state[stream_j];
      cipher = val ^ perm_state[t];
      emits = 1'b1;
    end
  endfunction

  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_word(input logic op, input byte_t val, input logic last, input bit drain);
    cipher_word_t w;
    w.op = op;
    w.val = val;
    w.last = last;
    w.drain_first = drain | drain_next;
    w.phase = build_phase;
    drain_next = 1'b0;
    word_backlog.push_back(w);
    words_built++;
  endtask

  task automatic queue_keyed_run(input int unsigned key_len, input int unsigned data_len);
    int unsigned k;
    for (k = 0; k < key_len; k++) begin
      queue_word(OP_KEY, pick_byte(), k == key_len - 1, k == 0 && $urandom_range(24) == 0);
    end
    for (k = 0; k < data_len; k++) begin
      if ($urandom_range(29) == 0) queue_word(OP_KEY, pick_byte(), 1'b0, 1'b0);
      queue_word(OP_DATA, pick_byte(), $urandom_range(19) == 0, 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin : drive_words
    bit offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_word.valid <= 1'b0;
    end else if (!(in_word.valid && !in_taken)) begin
      if (word_backlog.size() != 0 &&
          !(word_backlog[0].drain_first && cipher_expected.size() != 0)) begin
        offer = $urandom_range(99) >= tx_idle_pct[word_backlog[0].phase];
      end
      in_word.valid <= offer;
      if (offer) begin
        in_word.operation  <= word_backlog[0].op;
        in_word.byte_value <= word_backlog[0].val;
        in_word.key_last   <= word_backlog[0].last;
        traffic_phase      <= word_backlog[0].phase;
      end else begin
        in_word.operation  <= 1'($urandom_range(1));
        in_word.byte_value <= byte_t'($urandom_range(255));
        in_word.key_last   <= 1'($urandom_range(1));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_word.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_word.ready <= 1'b0;
    end else if (traffic_phase == 2 && !long_hold_done && out_word.valid) begin
      hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= $urandom_range(99) >= rx_idle_pct[traffic_phase];
    end
  end

  always @(posedge clk) begin : check_words
    bit    emits;
    byte_t want;
    in_taken <= rst_n && in_word.valid && in_word.ready;
    if (rst_n && in_word.valid && in_word.ready) begin
      rc4_advance(in_word.operation, in_word.byte_value, in_word.key_last, emits, want);
      if (emits) cipher_expected.push_back(want);
      void'(word_backlog.pop_front());
    end
    if (rst_n && out_word.valid && out_word.ready) begin
      if (cipher_expected.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Unexpected cipher word %02h with nothing pending.", out_word.cipher_byte);
        end
      end else begin
        want = cipher_expected.pop_front();
        results_checked++;
        if (out_word.cipher_byte !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Cipher word %0d: expected %02h, got %02h.", results_checked, want,
                     out_word.cipher_byte);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with %0d words unsent and %0d results pending.",
               word_backlog.size(), cipher_expected.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    rst_n = 1'b0;
    in_word.valid = 1'b0;
    in_word.operation = OP_KEY;
    in_word.byte_value = '0;
    in_word.key_last = 1'b0;
    out_word.ready = 1'b0;
    in_taken = 1'b0;
    traffic_phase = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    stall_cycles = 0;
    key_count = 0;
    stream_i = '0;
    stream_j = '0;
    for (n = 0; n < 256; n++) perm_state[n] = n[7:0];

    // Directed words: keystream on the reset permutation, key_last on data, a one-byte key,
    // key words arriving inside a stream, and an all-zero key.
    build_phase = 0;
    queue_word(OP_DATA, 8'h00, 1'b0, 1'b0);
    queue_word(OP_DATA, 8'hFF, 1'b0, 1'b0);
    queue_word(OP_DATA, 8'hA5, 1'b1, 1'b0);
    queue_word(OP_KEY,  8'hFF, 1'b1, 1'b0);
    queue_word(OP_DATA, 8'h00, 1'b0, 1'b0);
    queue_word(OP_DATA, 8'hFF, 1'b0, 1'b0);
    queue_word(OP_DATA, 8'h55, 1'b0, 1'b0);
    queue_word(OP_KEY,  8'h01, 1'b0, 1'b0);
    queue_word(OP_DATA, 8'hAA, 1'b0, 1'b0);
    queue_word(OP_KEY,  8'h80, 1'b1, 1'b0);
    queue_word(OP_DATA, 8'h00, 1'b0, 1'b1);
    queue_word(OP_DATA, 8'hFF, 1'b0, 1'b0);
    queue_word(OP_KEY,  8'h00, 1'b1, 1'b0);
    queue_word(OP_DATA, 8'h0F, 1'b0, 1'b0);

    while (words_built < 330) begin
      queue_keyed_run($urandom_range(9) == 0 ? $urandom_range(17, 64) : $urandom_range(1, 16),
                      $urandom_range(4, 48));
    end
    build_phase = 1;
    drain_next = 1'b1;
    while (words_built < 660) begin
      queue_keyed_run($urandom_range(9) == 0 ? $urandom_range(17, 64) : $urandom_range(1, 16),
                      $urandom_range(4, 48));
    end
    // The over-long key fills the store and ends on an ignored word marked last.
    build_phase = 2;
    drain_next = 1'b1;
    queue_keyed_run(KEY_CAPACITY + 2, 40);
    while (words_built < 1100) begin
      queue_keyed_run($urandom_range(9) == 0 ? $urandom_range(17, 64) : $urandom_range(1, 16),
                      $urandom_range(4, 48));
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (word_backlog.size() != 0 || cipher_expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (cipher_expected.size() != 0) error_count++;
    $display("Ran %0d key words through %0d schedules, including one key past the store size,",
             key_words, schedules_run);
    $display("and %0d data words with %0d cipher words checked under varied idling and stalls.",
             data_words, results_checked);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
